FILE: hdl/mlft_pkg.sv
// Shared types and constants for the MAC learning forward table.
package mlft_pkg;

	localparam int TableEntries = 8;
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int MacW = 48;
	localparam int PortW = 4;
	localparam int CntW = 4;
	localparam int CmdW = 2;
	localparam int StatusW = 3;

	typedef enum logic [CmdW-1:0] {
		CMD_LEARN   = 2'd0,
		CMD_FORWARD = 2'd1,
		CMD_CONNECT = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_LEARNED = 3'd0,
		ST_FULL    = 3'd1,
		ST_HIT     = 3'd2,
		ST_FLOOD   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		logic             hit;
		logic [IdxW-1:0]  hit_idx;
		logic [PortW-1:0] hit_port;
		logic [IdxW-1:0]  free_idx;
		logic [CntW-1:0]  count;
	} lookup_t;

	typedef struct packed {
		logic             wr;
		logic             alloc;
		logic             clear;
		logic [IdxW-1:0]  idx;
		logic [MacW-1:0]  mac;
		logic [PortW-1:0] port;
	} update_t;

endpackage

FILE: hdl/mac_learning_forward_table.sv
// MAC learning forward table: one command per cycle while the result side keeps up. A
// result is registered after its transaction is accepted: input register, then a parallel
// compare of the address against every entry feeding the result register. Each command
// sees the table as left by the one before it, so back-to-back commands are
// taken every cycle while the result side keeps up.
module mac_learning_forward_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mlft_pkg::CmdW-1:0]    command,
	input  logic [mlft_pkg::MacW-1:0]    mac,
	input  logic [mlft_pkg::PortW-1:0]   port,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mlft_pkg::StatusW-1:0] status,
	output logic [mlft_pkg::PortW-1:0]   out_port,
	output logic [mlft_pkg::CntW-1:0]    entry_count
);
	import mlft_pkg::*;

	logic               valid_s1;
	logic [CmdW-1:0]    cmd_s1;
	logic [MacW-1:0]    mac_s1;
	logic [PortW-1:0]   port_s1;
	logic               advance;
	lookup_t            lkp;
	update_t            upd;
	logic [StatusW-1:0] status_d;
	logic [PortW-1:0]   out_port_d;
	logic [CntW-1:0]    count_d;
	logic               out_valid_q;
	logic [StatusW-1:0] status_q;
	logic [PortW-1:0]   out_port_q;
	logic [CntW-1:0]    count_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			mac_s1  <= mac;
			port_s1 <= port;
		end
	end

	mlft_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_mac (mac_s1),
		.upd        (upd),
		.lkp        (lkp)
	);

	mlft_cmd u_cmd (
		.go          (advance),
		.command     (cmd_s1),
		.mac         (mac_s1),
		.port        (port_s1),
		.lkp         (lkp),
		.upd         (upd),
		.status      (status_d),
		.out_port    (out_port_d),
		.entry_count (count_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= status_d;
			out_port_q <= out_port_d;
			count_q    <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_port    = out_port_q;
	assign entry_count = count_q;

`ifndef ASSERT_OFF
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q <= CntW'(TableEntries)))
		else $error("entry count beyond capacity");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_FULL)) |-> (count_q == CntW'(TableEntries)))
		else $error("rejection while table not full");

	a_cleared_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_CLEARED)) |-> (count_q == '0))
		else $error("clear result with nonzero count");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(mac_s1) && $stable(cmd_s1)))
		else $error("stalled transaction lost in input stage");
`endif

endmodule

FILE: hdl/mlft_table.sv
// Address table storage with parallel match, free-entry search and update.
module mlft_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mlft_pkg::MacW-1:0]   lookup_mac,
	input  mlft_pkg::update_t           upd,
	output mlft_pkg::lookup_t           lkp
);
	import mlft_pkg::*;

	logic [TableEntries-1:0] valid_q;
	logic [MacW-1:0]         addr_q [TableEntries];
	logic [PortW-1:0]        port_q [TableEntries];
	logic [CntW-1:0]         count_q;

	always_comb begin
		lkp.hit      = 1'b0;
		lkp.hit_idx  = '0;
		lkp.hit_port = '0;
		lkp.free_idx = '0;
		lkp.count    = count_q;
		for (int i = TableEntries - 1; i >= 0; i--) begin
			if (valid_q[i] && (addr_q[i] == lookup_mac)) begin
				lkp.hit      = 1'b1;
				lkp.hit_idx  = IdxW'(i);
				lkp.hit_port = port_q[i];
			end
			if (!valid_q[i]) begin
				lkp.free_idx = IdxW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (upd.clear) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (upd.wr && upd.alloc) begin
			valid_q[upd.idx] <= 1'b1;
			count_q          <= count_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr) begin
			if (upd.alloc) begin
				addr_q[upd.idx] <= upd.mac;
			end
			port_q[upd.idx] <= upd.port;
		end
	end

`ifndef ASSERT_OFF
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CntW'($countones(valid_q)))
		else $error("entry count disagrees with valid entries");

	a_alloc_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.wr && upd.alloc && !upd.clear) |-> !valid_q[upd.idx])
		else $error("new entry placed on an occupied slot");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		upd.clear |=> (valid_q == '0) && (count_q == '0))
		else $error("table not empty after clear");
`endif

endmodule

FILE: hdl/mlft_cmd.sv
// Command decode: result fields and table update for one command.
module mlft_cmd (
	input  logic                         go,
	input  logic [mlft_pkg::CmdW-1:0]    command,
	input  logic [mlft_pkg::MacW-1:0]    mac,
	input  logic [mlft_pkg::PortW-1:0]   port,
	input  mlft_pkg::lookup_t            lkp,
	output mlft_pkg::update_t            upd,
	output logic [mlft_pkg::StatusW-1:0] status,
	output logic [mlft_pkg::PortW-1:0]   out_port,
	output logic [mlft_pkg::CntW-1:0]    entry_count
);
	import mlft_pkg::*;

	logic             full;
	logic [PortW-1:0] auto_port;
	logic [PortW-1:0] learn_port;
	cmd_t             cmd;

	assign cmd       = cmd_t'(command);
	assign full      = lkp.count >= CntW'(TableEntries);
	assign auto_port = full ? PortW'(1) : PortW'(lkp.count + CntW'(1));
	assign learn_port = (cmd == CMD_CONNECT) ? auto_port : port;

	always_comb begin
		upd.wr      = 1'b0;
		upd.alloc   = !lkp.hit;
		upd.clear   = 1'b0;
		upd.idx     = lkp.hit ? lkp.hit_idx : lkp.free_idx;
		upd.mac     = mac;
		upd.port    = learn_port;
		status      = ST_LEARNED;
		out_port    = '0;
		entry_count = lkp.count;
		unique case (cmd)
			CMD_LEARN, CMD_CONNECT: begin
				if (cmd == CMD_CONNECT) begin
					out_port = auto_port;
				end
				if (full) begin
					status = ST_FULL;
				end else begin
					status = ST_LEARNED;
					upd.wr = go;
					if (!lkp.hit) begin
						entry_count = lkp.count + CntW'(1);
					end
				end
			end
			CMD_FORWARD: begin
				if (lkp.hit) begin
					status   = ST_HIT;
					out_port = lkp.hit_port;
				end else begin
					status   = ST_FLOOD;
					out_port = port;
				end
			end
			CMD_CLEAR: begin
				upd.clear   = go;
				status      = ST_CLEARED;
				entry_count = '0;
			end
		endcase
	end

endmodule
